### src/tea_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types and constants for the TEA block encryption pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

  // Word and round geometry
  localparam int WORD_W    = 32;
  localparam int ROUNDS    = 32;
  localparam int LATENCY   = 2 * ROUNDS;
  localparam int SHIFT_L   = 4;
  localparam int SHIFT_R   = 5;
  localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 8'd3;

  // One word in flight: a is the word passed through, b the word to update
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } stage_t;

  // Key pair used by one half-round
  typedef struct packed {
    logic [WORD_W-1:0] kl;
    logic [WORD_W-1:0] kr;
  } key_pair_t;

  // Round sum for round r (zero based): delta times (r + 1), modulo 2^32
  function automatic logic [WORD_W-1:0] round_sum(input int r);
    logic [63:0] prod;
    prod = 64'(DELTA) * 64'(r + 1);
    return prod[WORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

### src/tea_half_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tea_half_round
// One registered Feistel half-round: adds the mix of the passed word into the
// updated word and swaps the pair on the way out.
// ----------------------------------------------------------------------------
module tea_half_round (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  tea_pkg::stage_t        din,
  input  wire  tea_pkg::key_pair_t     keys,
  input  wire  [tea_pkg::WORD_W-1:0]   sum,
  output tea_pkg::stage_t              dout
);

  logic [tea_pkg::WORD_W-1:0] term_l;
  logic [tea_pkg::WORD_W-1:0] term_s;
  logic [tea_pkg::WORD_W-1:0] term_r;
  logic [tea_pkg::WORD_W-1:0] mix;
  logic [tea_pkg::WORD_W-1:0] upd;

  // Mix the passed word with key pair and round sum
  always_comb begin
    term_l = (din.a << tea_pkg::SHIFT_L) + keys.kl;
    term_s = din.a + sum;
    term_r = (din.a >> tea_pkg::SHIFT_R) + keys.kr;
    mix    = term_l ^ term_s ^ term_r;
    upd    = din.b + mix;
  end

  // Advance the valid bit and swap the pair: the updated word is passed on
  // to the next half-round
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.a <= upd;
    dout.b <= din.a;
  end

endmodule
`default_nettype wire

### src/tea_block_encrypt_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tea_block_encrypt_top
// TEA encryption of 64-bit blocks with a 128-bit key, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive plain_first / plain_second and raise start; a word
//   is taken at every clock edge with start high and busy low. busy stays
//   low, so a new block can enter in every cycle.
//   Result channel: result_valid pulses for one cycle with cipher_first /
//   cipher_second. The receiver cannot stall; every result appears exactly
//   once, in input order.
//   The pipeline has two half-round stages for each of the 32 rounds, one
//   register per half-round; throughput is one block per cycle.
//   Configuration: cfg_valid / cfg_ready write key word cfg_index (0 to 3)
//   with cfg_data; cfg_ready is always high and other indexes are dropped.
//   Change the key only while no block is in flight.
//   Reset (rst, synchronous) clears the key to zero and drops all blocks in
//   flight; no result is produced for them.
// ----------------------------------------------------------------------------
module tea_block_encrypt_top (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  output logic                           busy,
  input  wire  [tea_pkg::WORD_W-1:0]     plain_first,
  input  wire  [tea_pkg::WORD_W-1:0]     plain_second,
  output logic                           result_valid,
  output logic [tea_pkg::WORD_W-1:0]     cipher_first,
  output logic [tea_pkg::WORD_W-1:0]     cipher_second,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [tea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [tea_pkg::WORD_W-1:0]     cfg_data
);

  logic [tea_pkg::WORD_W-1:0] key_word0;
  logic [tea_pkg::WORD_W-1:0] key_word1;
  logic [tea_pkg::WORD_W-1:0] key_word2;
  logic [tea_pkg::WORD_W-1:0] key_word3;

  tea_pkg::stage_t   pipe [0:tea_pkg::LATENCY];
  tea_pkg::key_pair_t keys_lo;
  tea_pkg::key_pair_t keys_hi;
  logic              accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Hold the key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0 <= '0;
      key_word1 <= '0;
      key_word2 <= '0;
      key_word3 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tea_pkg::REG_KEY0: key_word0 <= cfg_data;
        tea_pkg::REG_KEY1: key_word1 <= cfg_data;
        tea_pkg::REG_KEY2: key_word2 <= cfg_data;
        tea_pkg::REG_KEY3: key_word3 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign keys_lo = '{kl: key_word0, kr: key_word1};
  assign keys_hi = '{kl: key_word2, kr: key_word3};

  // Feed the first stage: second is mixed into first
  assign pipe[0] = '{valid: accept, a: plain_second, b: plain_first};

  // One stage per half-round
  for (genvar k = 0; k < tea_pkg::LATENCY; k++) begin : g_stage
    tea_half_round u_half (
      .clk  (clk),
      .rst  (rst),
      .din  (pipe[k]),
      .keys ((k % 2 == 0) ? keys_lo : keys_hi),
      .sum  (tea_pkg::round_sum(k / 2)),
      .dout (pipe[k+1])
    );
  end

  // Drive the result word; after an even number of swaps the pair is in order
  assign result_valid  = pipe[tea_pkg::LATENCY].valid;
  assign cipher_first  = pipe[tea_pkg::LATENCY].b;
  assign cipher_second = pipe[tea_pkg::LATENCY].a;

  // Every result traces back to a word taken at the pipeline entry
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept, tea_pkg::LATENCY))
    else $error("result without a matching input word");

  // A taken word enters the first pipeline register
  a_first_stage_loaded: assert property (@(posedge clk)
    !$past(rst) && $past(accept) |-> pipe[1].valid)
    else $error("accepted word lost at pipeline entry");

  // A key write lands in the addressed register
  a_key0_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == tea_pkg::REG_KEY0
      |=> key_word0 == $past(cfg_data))
    else $error("key word 0 write not applied");

  a_key3_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == tea_pkg::REG_KEY3
      |=> key_word3 == $past(cfg_data))
    else $error("key word 3 write not applied");

endmodule
`default_nettype wire

### test/tea_block_encrypt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tea_block_encrypt_checker
// Watches the key, block and result channels of the TEA encryption pipeline.
// Keeps a shadow of the 128-bit key, encrypts every accepted plaintext word
// on its own and compares each result word, in order, with that prediction.
// ----------------------------------------------------------------------------
module tea_block_encrypt_checker (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  input  wire                            busy,
  input  wire  [tea_pkg::WORD_W-1:0]     plain_first,
  input  wire  [tea_pkg::WORD_W-1:0]     plain_second,
  input  wire                            result_valid,
  input  wire  [tea_pkg::WORD_W-1:0]     cipher_first,
  input  wire  [tea_pkg::WORD_W-1:0]     cipher_second,
  input  wire                            cfg_valid,
  input  wire                            cfg_ready,
  input  wire  [tea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [tea_pkg::WORD_W-1:0]     cfg_data,
  output int                             error_count,
  output int                             blocks_in_flight,
  output int                             blocks_checked
);

  localparam int W = tea_pkg::WORD_W;

  typedef struct packed {
    logic [W-1:0] first;
    logic [W-1:0] second;
  } cipher_block_t;

  logic [3:0][W-1:0] key_shadow = '0;
  cipher_block_t     pending_ciphers[$];
  int                mismatch_total = 0;
  int                compared_total = 0;
  int                pending_total  = 0;

  assign error_count      = mismatch_total;
  assign blocks_checked   = compared_total;
  assign blocks_in_flight = pending_total;

  // One half-round: shifted and summed copies of a word, folded by xor
  function automatic logic [W-1:0] feistel_mix(input logic [W-1:0] word,
                                               input logic [W-1:0] sum,
                                               input logic [W-1:0] key_left,
                                               input logic [W-1:0] key_right);
    return ((word << tea_pkg::SHIFT_L) + key_left) ^ (word + sum) ^
           ((word >> tea_pkg::SHIFT_R) + key_right);
  endfunction

  // Full encryption of one block under the given key
  function automatic cipher_block_t tea_encrypt(input logic [W-1:0] first,
                                                input logic [W-1:0] second,
                                                input logic [3:0][W-1:0] key);
    logic [W-1:0]  left;
    logic [W-1:0]  right;
    logic [W-1:0]  sum;
    cipher_block_t block;
    left  = first;
    right = second;
    sum   = '0;
    for (int r = 0; r < tea_pkg::ROUNDS; r++) begin
      sum   = sum + tea_pkg::DELTA;
      left  = left + feistel_mix(right, sum, key[0], key[1]);
      right = right + feistel_mix(left, sum, key[2], key[3]);
    end
    block.first  = left;
    block.second = right;
    return block;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_total++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Track key writes, queue predictions, compare result words
  always @(posedge clk) begin
    cipher_block_t want;
    if (rst) begin
      pending_ciphers.delete();
      key_shadow = '0;
    end else begin
      if (start && !busy) begin
        pending_ciphers.push_back(tea_encrypt(plain_first, plain_second, key_shadow));
      end
      if (result_valid) begin
        if (pending_ciphers.size() == 0) begin
          report_mismatch($sformatf("result word %08h_%08h with no block outstanding",
                                    cipher_first, cipher_second));
        end else begin
          want = pending_ciphers.pop_front();
          compared_total++;
          if (cipher_first !== want.first) begin
            report_mismatch($sformatf("cipher_first got %08h want %08h",
                                      cipher_first, want.first));
          end
          if (cipher_second !== want.second) begin
            report_mismatch($sformatf("cipher_second got %08h want %08h",
                                      cipher_second, want.second));
          end
        end
      end
      // Indexes past the last key word are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tea_pkg::REG_KEY0: key_shadow[0] = cfg_data;
          tea_pkg::REG_KEY1: key_shadow[1] = cfg_data;
          tea_pkg::REG_KEY2: key_shadow[2] = cfg_data;
          tea_pkg::REG_KEY3: key_shadow[3] = cfg_data;
          default: ;
        endcase
      end
    end
    pending_total = pending_ciphers.size();
  end

endmodule

### test/tea_block_encrypt_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tea_block_encrypt_top_test
// Drives plaintext words and key writes into the TEA encryption pipeline.
// A directed set covers the word extremes under the reset key and an all-ones
// key; random phases then load fresh keys (extremes among them) and stream
// blocks with bursts and random gaps, draining the pipeline between phases.
// ----------------------------------------------------------------------------
module tea_block_encrypt_top_test;

  localparam int W              = tea_pkg::WORD_W;
  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_BLOCKS   = 72;
  localparam int MAX_GAP        = 11;
  localparam int SETTLE_CYCLES  = tea_pkg::LATENCY + 8;
  localparam logic [tea_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 8'd4;
  localparam logic [tea_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 8'hff;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          start        = 1'b0;
  logic [W-1:0]                  plain_first  = '0;
  logic [W-1:0]                  plain_second = '0;
  logic                          cfg_valid    = 1'b0;
  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
  logic [W-1:0]                  cfg_data     = '0;
  wire                           busy;
  wire                           result_valid;
  wire  [W-1:0]                  cipher_first;
  wire  [W-1:0]                  cipher_second;
  wire                           cfg_ready;

  int error_count;
  int blocks_in_flight;
  int blocks_checked;
  int blocks_sent  = 0;
  int key_settings = 0;
  int cycle_count  = 0;
  bit gaps_on      = 1'b0;

  tea_block_encrypt_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .plain_first   (plain_first),
    .plain_second  (plain_second),
    .result_valid  (result_valid),
    .cipher_first  (cipher_first),
    .cipher_second (cipher_second),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  tea_block_encrypt_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .plain_first      (plain_first),
    .plain_second     (plain_second),
    .result_valid     (result_valid),
    .cipher_first     (cipher_first),
    .cipher_second    (cipher_second),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .error_count      (error_count),
    .blocks_in_flight (blocks_in_flight),
    .blocks_checked   (blocks_checked)
  );

  always begin
    clk = 1'b1;
    #(CLK_HALF);
    clk = 1'b0;
    #(CLK_HALF);
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d blocks in flight", cycle_count, blocks_in_flight);
    $display("tea_block_encrypt_top verification failed");
    $finish;
  end

  // Mostly uniform words, with zero, all ones and single-bit patterns mixed in
  function automatic logic [W-1:0] draw_word();
    logic [W-1:0] bit_mask;
    bit_mask = {{(W-1){1'b0}}, 1'b1} << $urandom_range(0, W-1);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return bit_mask;
      3:       return ~bit_mask;
      default: return $urandom;
    endcase
  endfunction

  // Write one register word; valid stays up for a following write
  task automatic write_reg(input logic [tea_pkg::CFG_IDX_W-1:0] idx, input logic [W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Load all four key words, then a write to an unused index that must be dropped
  task automatic load_key(input logic [3:0][W-1:0] key);
    write_reg(tea_pkg::REG_KEY0, key[0]);
    write_reg(tea_pkg::REG_KEY1, key[1]);
    write_reg(tea_pkg::REG_KEY2, key[2]);
    write_reg(tea_pkg::REG_KEY3, key[3]);
    write_reg(tea_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
    cfg_valid <= 1'b0;
    key_settings++;
  endtask

  // Hand one plaintext word over, then idle for a drawn gap
  task automatic send_block(input logic [W-1:0] first, input logic [W-1:0] second);
    int gap;
    plain_first  <= first;
    plain_second <= second;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    blocks_sent++;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every outstanding block has come back
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (blocks_in_flight != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic directed_blocks();
    send_block('0, '0);
    send_block('1, '1);
    send_block('0, '1);
    send_block('1, '0);
    send_block(32'h8000_0000, 32'h0000_0001);
    send_block(32'h0000_0001, 32'h8000_0000);
    send_block(32'haaaa_aaaa, 32'h5555_5555);
    send_block(32'h0123_4567, 32'h89ab_cdef);
  endtask

  initial begin
    logic [3:0][W-1:0] key;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset key, never written: back-to-back, then the all-ones key with gaps
    directed_blocks();
    drain();
    key = '1;
    load_key(key);
    gaps_on = 1'b1;
    directed_blocks();
    drain();

    // Random phases, each under a new key and its own idle mix
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       key = '0;
        1:       key = {32'h8000_0000, 32'h0000_0001, 32'hffff_fffe, 32'h7fff_ffff};
        default: begin
          for (int k = 0; k < 4; k++) key[k] = draw_word();
        end
      endcase
      load_key(key);
      gaps_on = (p % 3) != 2;
      for (int i = 0; i < PHASE_BLOCKS; i++) begin
        send_block(draw_word(), draw_word());
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("encrypted %0d blocks under %0d key loads, %0d results compared",
             blocks_sent, key_settings, blocks_checked);
    $display("phases mixed back-to-back streams with gaps of up to %0d cycles", MAX_GAP);
    if (error_count == 0 && blocks_in_flight == 0) begin
      $display("tea_block_encrypt_top verification clean");
    end else begin
      $display("%0d mismatches, %0d blocks left outstanding", error_count, blocks_in_flight);
      $display("tea_block_encrypt_top verification failed");
    end
    $finish;
  end

endmodule
